// ----- rtl/core/vtpd_pkg.sv -----
// Package for the vertex transform and perspective divide block.
// Holds the payload structs, the fixed-point constants and the shared widths.
`timescale 1ns / 1ps
`default_nettype none
package vtpd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 3;
  // Products are 64 bits; the row sum of three products plus an entry fits 67 bits.
  localparam int SUM_W     = 67;
  // Transformed component after the shift.
  localparam int T_W       = SUM_W - FRAC_BITS;
  // Magnitude of a component (|T| < 2^(T_W-1) plus one bit headroom).
  localparam int MAG_W     = T_W;
  // Quotient bits kept: 32 plus a saturation guard bit.
  localparam int Q_W       = 33;
  // Dividend magnitude is |T| * 2^FRAC_BITS.
  localparam int N_W       = MAG_W + FRAC_BITS;
  localparam int STEPS     = N_W;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic               in_last;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divide_fault;
    logic               out_last;
  } vtx_out_t;

  // State of one lane of the divider chain.
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [N_W-1:0]   num;
    logic [Q_W-1:0]   quo;
    logic             ovf;
  } div_lane_t;

  // What travels alongside the three division lanes.
  typedef struct packed {
    logic [MAG_W-1:0] den;
    logic [2:0]       neg;
    logic [2:0]       nonneg_num;
    logic             fault;
    logic             last;
  } div_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/vertex_transform_perspective_divide.sv -----
// Vertex transform and perspective divide: item in, one result item out.
// Clock clk, synchronous active-low reset rst_n. Both channels use valid and
// stall; an item moves at an edge where valid is high and stall is low.
// The configuration port writes one 64-bit matrix register per cycle
// (index 0..7, two Q16.16 entries each); reset loads the identity matrix.
// The 3-bit index reaches all eight registers. Write only while the block is idle.
// Throughput: one vertex per cycle while the output is not stalled. Stages: the
// matrix multiply (vertex, product and sum registers), the sign/magnitude set-up,
// the divider chain (a row of identical cells, one quotient bit each), and the
// saturation into the output register; the dividend width sets the chain length.
// The whole pipeline advances when the output register is empty or taken, so
// a stall from the receiver freezes every stage and holds out_item stable;
// in_stall is then high. Reset empties the pipeline.
// Depends on vtpd_pkg, vtpd_xform and vtpd_div_cell.
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_perspective_divide (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vtpd_pkg::vtx_in_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vtpd_pkg::vtx_out_t       out_item,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import vtpd_pkg::*;

  logic [63:0] mat_r [NUM_REGS];
  logic        adv;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= 64'd65536;
      mat_r[1] <= 64'd0;
      mat_r[2] <= 64'd1 << 48;
      mat_r[3] <= 64'd0;
      mat_r[4] <= 64'd0;
      mat_r[5] <= 64'd65536;
      mat_r[6] <= 64'd0;
      mat_r[7] <= 64'd1 << 48;
    end else if (cfg_we) begin
      mat_r[cfg_index[IDX_W-1:0]] <= cfg_data;
    end
  end

  logic                  xf_vld, xf_last;
  logic signed [T_W-1:0] t [4];

  vtpd_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_item  (in_item),
    .mat      (mat_r),
    .out_vld  (xf_vld),
    .t_out    (t),
    .out_last (xf_last)
  );

  // Sign/magnitude set-up feeding the divider chain.
  div_lane_t lane_s [STEPS+1][3];
  div_ctl_t  ctl_s  [STEPS+1];
  logic      vld_s  [STEPS+1];
  div_lane_t lane0_r [3];
  div_ctl_t  ctl0_r;
  logic      vld0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= xf_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl0_r.den   <= t[3][T_W-1] ? MAG_W'(-t[3]) : MAG_W'(t[3]);
      ctl0_r.fault <= (t[3] == '0);
      ctl0_r.last  <= xf_last;
      for (int i = 0; i < 3; i++) begin
        ctl0_r.neg[i]        <= t[i][T_W-1] ^ t[3][T_W-1];
        ctl0_r.nonneg_num[i] <= !t[i][T_W-1];
        lane0_r[i].rem <= '0;
        lane0_r[i].num <= {(t[i][T_W-1] ? MAG_W'(-t[i]) : MAG_W'(t[i])),
                           {FRAC_BITS{1'b0}}};
        lane0_r[i].quo <= '0;
        lane0_r[i].ovf <= 1'b0;
      end
    end
  end

  assign lane_s[0] = lane0_r;
  assign ctl_s[0]  = ctl0_r;
  assign vld_s[0]  = vld0_r;

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    vtpd_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (vld_s[g]),
      .in_lane  (lane_s[g]),
      .in_ctl   (ctl_s[g]),
      .out_vld  (vld_s[g+1]),
      .out_lane (lane_s[g+1]),
      .out_ctl  (ctl_s[g+1])
    );
  end

  // Saturation into the output register.
  logic [31:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic big;
      big = lane_s[STEPS][i].ovf || lane_s[STEPS][i].quo[Q_W-1];
      if (ctl_s[STEPS].fault) begin
        res[i] = ctl_s[STEPS].nonneg_num[i] ? SAT_POS : SAT_NEG;
      end else if (ctl_s[STEPS].neg[i]) begin
        if (big || lane_s[STEPS][i].quo[31]) res[i] = SAT_NEG;
        else res[i] = 32'(-lane_s[STEPS][i].quo[31:0]);
      end else begin
        if (big || lane_s[STEPS][i].quo[31]) res[i] = SAT_POS;
        else res[i] = lane_s[STEPS][i].quo[31:0];
      end
    end
  end

  logic vld_o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (adv) begin
      vld_o_r <= vld_s[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.out_x        <= res[0];
      out_item.out_y        <= res[1];
      out_item.out_z        <= res[2];
      out_item.divide_fault <= ctl_s[STEPS].fault;
      out_item.out_last     <= ctl_s[STEPS].last;
    end
  end

  assign out_valid = vld_o_r;
endmodule
`default_nettype wire

// ----- rtl/core/vtpd_xform.sv -----
// Matrix multiply stage: registers the vertex, then the products, then the four
// transformed components. Depends on vtpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vtpd_xform (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         in_vld,
  input  wire vtpd_pkg::vtx_in_t            in_item,
  input  wire logic [63:0]                  mat [vtpd_pkg::NUM_REGS],
  output logic                              out_vld,
  output logic signed [vtpd_pkg::T_W-1:0]   t_out [4],
  output logic                              out_last
);
  import vtpd_pkg::*;

  logic signed [31:0] vx_r [3];
  logic               v1_r, v2_r, v3_r, l1_r, l2_r, l3_r;
  logic signed [63:0] prod_r [4][3];
  logic signed [31:0] wcol_r [4];
  logic signed [T_W-1:0] t_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0] <= in_item.in_x;
      vx_r[1] <= in_item.in_y;
      vx_r[2] <= in_item.in_z;
      l1_r    <= in_item.in_last;
      l2_r    <= l1_r;
      l3_r    <= l2_r;
      for (int r = 0; r < 4; r++) begin
        wcol_r[r] <= mat[2*r+1][63:32];
        prod_r[r][0] <= $signed(mat[2*r][31:0]) * vx_r[0];
        prod_r[r][1] <= $signed(mat[2*r][63:32]) * vx_r[1];
        prod_r[r][2] <= $signed(mat[2*r+1][31:0]) * vx_r[2];
        // Exact sum, then floor shift (arithmetic shift).
        t_r[r] <= T_W'((SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1])
                  + SUM_W'(prod_r[r][2])
                  + (SUM_W'(wcol_r[r]) <<< FRAC_BITS)) >>> FRAC_BITS);
      end
    end
  end

  assign out_vld  = v3_r;
  assign t_out    = t_r;
  assign out_last = l3_r;
endmodule
`default_nettype wire

// ----- rtl/core/vtpd_div_cell.sv -----
// One cell of the restoring divider chain: one quotient bit for each of the
// three lanes per cycle while the pipeline advances. Depends on vtpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vtpd_div_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_vld,
  input  wire vtpd_pkg::div_lane_t in_lane [3],
  input  wire vtpd_pkg::div_ctl_t  in_ctl,
  output logic                     out_vld,
  output vtpd_pkg::div_lane_t      out_lane [3],
  output vtpd_pkg::div_ctl_t       out_ctl
);
  import vtpd_pkg::*;

  div_lane_t lane_r [3];
  div_ctl_t  ctl_r;
  logic      vld_r;
  div_lane_t lane_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [MAG_W:0] trial;
      trial = {in_lane[i].rem, in_lane[i].num[N_W-1]};
      lane_nxt[i].num = {in_lane[i].num[N_W-2:0], 1'b0};
      lane_nxt[i].ovf = in_lane[i].ovf | in_lane[i].quo[Q_W-1];
      if (trial >= {1'b0, in_ctl.den}) begin
        lane_nxt[i].rem = MAG_W'(trial - {1'b0, in_ctl.den});
        lane_nxt[i].quo = {in_lane[i].quo[Q_W-2:0], 1'b1};
      end else begin
        lane_nxt[i].rem = MAG_W'(trial);
        lane_nxt[i].quo = {in_lane[i].quo[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
      ctl_r  <= in_ctl;
    end
  end

  assign out_vld  = vld_r;
  assign out_lane = lane_r;
  assign out_ctl  = ctl_r;
endmodule
`default_nettype wire

// ----- rtl/core/vtpd_checker.sv -----
// Port-level checks for the vertex transform block, bound to the top level.
// Depends on vtpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vtpd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire vtpd_pkg::vtx_out_t out_item
);
  import vtpd_pkg::*;

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed under stall");

  // Input is stalled exactly when a held result waits.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output");

  // A fault result carries a saturated coordinate.
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.divide_fault |->
      (out_item.out_x == SAT_POS || out_item.out_x == SAT_NEG))
    else $error("fault without saturation");

  // Nothing leaves right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind vertex_transform_perspective_divide vtpd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire
